// File: rtl/core/rdf_pkg.sv
// Shared types, command codes and rectangle setup for the framebuffer draw engine.
package rdf_pkg;

    localparam int COLS_DEF = 64;
    localparam int ROWS_DEF = 32;

    // Coordinate width: wide enough for an edge at pos + size + 1.
    localparam int CW = 9;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_PLOT    = 3'd1;
    localparam logic [2:0] CMD_OUTLINE = 3'd2;
    localparam logic [2:0] CMD_FILL    = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    localparam logic [1:0] SEG_TOP    = 2'd0;
    localparam logic [1:0] SEG_BOTTOM = 2'd1;
    localparam logic [1:0] SEG_LEFT   = 2'd2;
    localparam logic [1:0] SEG_RIGHT  = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] size_w;
        logic [7:0] size_h;
    } rdf_cmd_word_t;

    typedef struct packed {
        logic pixel_lit;
        logic in_range;
    } rdf_rsp_word_t;

    // Half-open rectangle: columns c0..c1-1, rows r0..r1-1.
    typedef struct packed {
        logic [CW-1:0] c0;
        logic [CW-1:0] c1;
        logic [CW-1:0] r0;
        logic [CW-1:0] r1;
    } rdf_rect_t;

    function automatic rdf_rect_t seg_rect(
        input logic [2:0] cmd,
        input logic [1:0] seg,
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] w,
        input logic [7:0] h
    );
        rdf_rect_t     rect;
        logic [CW-1:0] xe;
        logic [CW-1:0] ye;
        logic [CW-1:0] xr;
        logic [CW-1:0] yb;
        xe = {1'b0, x};
        ye = {1'b0, y};
        xr = xe + {1'b0, w};
        yb = ye + {1'b0, h};
        rect = '0;
        unique case (cmd)
            CMD_CLEAR:
            begin
                rect.c0 = '0;
                rect.c1 = '1;
                rect.r0 = '0;
                rect.r1 = '1;
            end
            CMD_PLOT:
            begin
                rect.c0 = xe;
                rect.c1 = xe + CW'(1);
                rect.r0 = ye;
                rect.r1 = ye + CW'(1);
            end
            CMD_FILL:
            begin
                rect.c0 = xe;
                rect.c1 = xr;
                rect.r0 = ye;
                rect.r1 = yb;
            end
            CMD_OUTLINE:
            begin
                unique case (seg)
                    SEG_TOP:
                    begin
                        rect.c0 = xe;
                        rect.c1 = xr + CW'(1);
                        rect.r0 = ye;
                        rect.r1 = ye + CW'(1);
                    end
                    SEG_BOTTOM:
                    begin
                        rect.c0 = xe;
                        rect.c1 = xr + CW'(1);
                        rect.r0 = yb;
                        rect.r1 = yb + CW'(1);
                    end
                    SEG_LEFT:
                    begin
                        rect.c0 = xe;
                        rect.c1 = xe + CW'(1);
                        rect.r0 = ye;
                        rect.r1 = yb + CW'(1);
                    end
                    default:
                    begin
                        rect.c0 = xr;
                        rect.c1 = xr + CW'(1);
                        rect.r0 = ye;
                        rect.r1 = yb + CW'(1);
                    end
                endcase
            end
            default:
            begin
                rect = '0;
            end
        endcase
        return rect;
    endfunction

    function automatic logic seg_last(input logic [2:0] cmd, input logic [1:0] seg);
        return (cmd != CMD_OUTLINE) || (seg == SEG_RIGHT);
    endfunction

endpackage

// File: rtl/core/rdf_walker.sv
// Rectangle walker: clips a rectangle to the screen and steps one cell address per cycle.
module rdf_walker
    import rdf_pkg::*;
#(
    parameter int COLS   = COLS_DEF,
    parameter int ROWS   = ROWS_DEF,
    parameter int ADDR_W = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rdf_rect_t         rect,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic              done
);

    typedef enum logic [1:0] {W_IDLE, W_RUN, W_DONE} walk_state_t;

    walk_state_t   state_reg, state_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] c0_reg, c0_next;
    logic [CW-1:0] cend_reg, cend_next;
    logic [CW-1:0] rend_reg, rend_next;

    logic [CW-1:0] clip_c1;
    logic [CW-1:0] clip_r1;
    logic [CW-1:0] c_inc;
    logic [CW-1:0] r_inc;

    always_comb
    begin
        clip_c1 = (rect.c1 > CW'(COLS)) ? CW'(COLS) : rect.c1;
        clip_r1 = (rect.r1 > CW'(ROWS)) ? CW'(ROWS) : rect.r1;
        c_inc   = c_reg + CW'(1);
        r_inc   = r_reg + CW'(1);

        state_next = state_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        c0_next    = c0_reg;
        cend_next  = cend_reg;
        rend_next  = rend_reg;

        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    c_next    = rect.c0;
                    r_next    = rect.r0;
                    c0_next   = rect.c0;
                    cend_next = clip_c1;
                    rend_next = clip_r1;
                    if ((rect.c0 >= clip_c1) || (rect.r0 >= clip_r1))
                        state_next = W_DONE;
                    else
                        state_next = W_RUN;
                end
            end
            W_RUN:
            begin
                if (c_inc >= cend_reg)
                begin
                    c_next = c0_reg;
                    r_next = r_inc;
                    if (r_inc >= rend_reg)
                        state_next = W_DONE;
                end
                else
                begin
                    c_next = c_inc;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        r_reg    <= r_next;
        c0_reg   <= c0_next;
        cend_reg <= cend_next;
        rend_reg <= rend_next;
    end

    assign wr_en   = (state_reg == W_RUN);
    assign wr_addr = ADDR_W'(r_reg) * ADDR_W'(COLS) + ADDR_W'(c_reg);
    assign done    = (state_reg == W_DONE);

endmodule

// File: rtl/core/rect_draw_framebuffer_top.sv
// Top level of the framebuffer draw engine: command sequencer, cell store and response register.
// Throughput: one command at a time, the walker writing one cell per cycle.
// Reset: a clearing pass zeroes the store; cmd_ready stays low until that pass ends.
// A finished response waits in its register while the next command is taken.
module rect_draw_framebuffer_top
    import rdf_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rdf_cmd_word_t cmd_word,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rdf_rsp_word_t rsp_word
);

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_LAUNCH, S_WAIT, S_READ, S_READ_DATA, S_DONE}
        seq_state_t;

    seq_state_t    state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [7:0]    x_reg, x_next;
    logic [7:0]    y_reg, y_next;
    logic [7:0]    w_reg, w_next;
    logic [7:0]    h_reg, h_next;
    logic [1:0]    seg_reg, seg_next;
    logic          init_reg, init_next;
    logic          on_reg, on_next;
    logic          lit_reg, lit_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rdf_rsp_word_t rsp_reg, rsp_next;

    logic              mem [DEPTH];
    logic              rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic              walk_start;
    rdf_rect_t         walk_rect;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              walk_done;
    logic              accept;
    logic              on_now;

    assign walk_start = (state_reg == S_LAUNCH);
    assign walk_rect  = seg_rect(cmd_reg, seg_reg, x_reg, y_reg, w_reg, h_reg);

    rdf_walker #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .rect    (walk_rect),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .done    (walk_done)
    );

    assign rd_addr = on_reg ? (ADDR_W'(y_reg) * ADDR_W'(COLS) + ADDR_W'(x_reg)) : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= (cmd_reg != CMD_CLEAR);
        rd_data_reg <= mem[rd_addr];
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign on_now    = ({1'b0, cmd_word.pos_x} < CW'(COLS))
                    && ({1'b0, cmd_word.pos_y} < CW'(ROWS));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        seg_next       = seg_reg;
        init_next      = init_reg;
        on_next        = on_reg;
        lit_next       = lit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_word.command;
                    x_next   = cmd_word.pos_x;
                    y_next   = cmd_word.pos_y;
                    w_next   = cmd_word.size_w;
                    h_next   = cmd_word.size_h;
                    on_next  = on_now;
                    lit_next = 1'b0;
                    seg_next = SEG_TOP;
                    priority if (cmd_word.command == CMD_READ)
                        state_next = S_READ;
                    else if (cmd_word.command > CMD_READ)
                        state_next = S_DONE;
                    else
                        state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (walk_done)
                begin
                    if (!seg_last(cmd_reg, seg_reg))
                    begin
                        seg_next   = seg_reg + 2'd1;
                        state_next = S_LAUNCH;
                    end
                    else if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_READ_DATA;
            end
            S_READ_DATA:
            begin
                lit_next   = on_reg & rd_data_reg;
                state_next = S_DONE;
            end
            default:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.pixel_lit = lit_reg;
                    rsp_next.in_range  = on_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LAUNCH;
            cmd_reg       <= CMD_CLEAR;
            seg_reg       <= SEG_TOP;
            init_reg      <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            seg_reg       <= seg_next;
            init_reg      <= init_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        w_reg   <= w_next;
        h_reg   <= h_next;
        on_reg  <= on_next;
        lit_reg <= lit_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

// File: tb/rect_draw_framebuffer_top_test.sv
// Self-checking testbench for the framebuffer draw engine: random and directed draw commands.
module rect_draw_framebuffer_top_test;
    import rdf_pkg::*;

    localparam int SCR_COLS = COLS_DEF;
    localparam int SCR_ROWS = ROWS_DEF;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int RX_OPEN   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;

    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_RSP  = 120;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_WORDS = 265;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_ready;
    rdf_cmd_word_t cmd_word = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    rdf_rsp_word_t rsp_word;

    rdf_cmd_word_t cmd_queue[$];
    rdf_rsp_word_t rsp_expect_q[$];
    bit            screen_bits[SCR_ROWS * SCR_COLS];

    int            cmd_kind_count[8];
    int            cmd_taken = 0;
    int            rsp_checked = 0;
    int            lit_reads = 0;
    int            fail_count = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            rx_count = 0;
    int            rx_mode = RX_OPEN;
    int            rx_mode_left = 0;
    int            hold_left = 0;
    bit            long_hold_done = 1'b0;
    int            idle_cycles = 0;
    int            last_x = 0;
    int            last_y = 0;
    int            last_w = 0;
    int            last_h = 0;
    rdf_rsp_word_t rsp_want;

    rect_draw_framebuffer_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void light_cell(int col, int row);
        if (col < SCR_COLS && row < SCR_ROWS)
            screen_bits[row * SCR_COLS + col] = 1'b1;
    endfunction

    function automatic rdf_rsp_word_t draw_and_sample(rdf_cmd_word_t word);
        rdf_rsp_word_t rsp;
        int            x;
        int            y;
        int            w;
        int            h;
        x = word.pos_x;
        y = word.pos_y;
        w = word.size_w;
        h = word.size_h;
        rsp.in_range = (x < SCR_COLS) && (y < SCR_ROWS);
        rsp.pixel_lit = 1'b0;
        case (word.command)
            CMD_CLEAR:
            begin
                foreach (screen_bits[i])
                    screen_bits[i] = 1'b0;
            end
            CMD_PLOT:
            begin
                light_cell(x, y);
            end
            CMD_OUTLINE:
            begin
                for (int i = x; i <= x + w; i++)
                begin
                    light_cell(i, y);
                    light_cell(i, y + h);
                end
                for (int i = y; i <= y + h; i++)
                begin
                    light_cell(x, i);
                    light_cell(x + w, i);
                end
            end
            CMD_FILL:
            begin
                for (int c = x; c < x + w && c < SCR_COLS; c++)
                    for (int r = y; r < y + h && r < SCR_ROWS; r++)
                        light_cell(c, r);
            end
            CMD_READ:
            begin
                if (rsp.in_range)
                    rsp.pixel_lit = screen_bits[y * SCR_COLS + x];
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    task automatic add_word(logic [2:0] cmd, int x, int y, int w, int h);
        rdf_cmd_word_t word;
        word.command = cmd;
        word.pos_x = 8'(x);
        word.pos_y = 8'(y);
        word.size_w = 8'(w);
        word.size_h = 8'(h);
        cmd_queue.push_back(word);
    endtask

    task automatic add_random_word();
        int pick;
        int x;
        int y;
        int w;
        int h;
        pick = $urandom_range(0, 99);
        x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, SCR_COLS + 3);
        y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, SCR_ROWS + 3);
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        if (pick < 3)
            add_word(CMD_CLEAR, x, y, w, h);
        else if (pick < 18)
            add_word(CMD_PLOT, x, y, w, h);
        else if (pick < 48)
        begin
            add_word((pick < 33) ? CMD_OUTLINE : CMD_FILL, x, y, w, h);
            last_x = x;
            last_y = y;
            last_w = w;
            last_h = h;
        end
        else if (pick < 95)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                x = last_x + $urandom_range(0, last_w + 1);
                y = last_y + $urandom_range(0, last_h + 1);
            end
            add_word(CMD_READ, x, y, w, h);
        end
        else
            add_word(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), x, y, w, h);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_valid || rsp_expect_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                rsp_expect_q.push_back(draw_and_sample(cmd_word));
                cmd_kind_count[cmd_word.command]++;
                cmd_taken++;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (gap_left > 0 || cmd_queue.size() == 0)
                begin
                    cmd_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    cmd_valid <= 1'b1;
                    cmd_word <= cmd_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
                rx_count++;
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(RX_OPEN, RX_SPARSE);
                rx_mode_left = $urandom_range(16, 96);
            end
            else
                rx_mode_left--;
            if (!long_hold_done && rx_count >= HOLD_AT_RSP)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (rx_mode == RX_OPEN)
                rsp_ready <= 1'b1;
            else if (rx_mode == RX_HALF)
                rsp_ready <= 1'($urandom_range(0, 1));
            else
                rsp_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_checked++;
            if (rsp_expect_q.size() == 0)
            begin
                $error("response word with nothing expected: %b", rsp_word);
                fail_count++;
            end
            else
            begin
                rsp_want = rsp_expect_q.pop_front();
                if (rsp_word.pixel_lit !== rsp_want.pixel_lit)
                begin
                    $error("pixel_lit: expected %0d, got %0d", rsp_want.pixel_lit,
                           rsp_word.pixel_lit);
                    fail_count++;
                end
                if (rsp_word.in_range !== rsp_want.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", rsp_want.in_range,
                           rsp_word.in_range);
                    fail_count++;
                end
                if (rsp_want.pixel_lit)
                    lit_reads++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no word moved for %0d cycles", IDLE_LIMIT);
            $display("rect_draw_framebuffer_top_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        add_word(CMD_CLEAR, 0, 0, 0, 0);
        add_word(CMD_READ, 0, 0, 0, 0);
        add_word(CMD_PLOT, 0, 0, 0, 0);
        add_word(CMD_PLOT, SCR_COLS - 1, SCR_ROWS - 1, 255, 255);
        add_word(CMD_PLOT, SCR_COLS, 5, 0, 0);
        add_word(CMD_PLOT, 5, SCR_ROWS, 0, 0);
        add_word(CMD_PLOT, 255, 255, 0, 0);
        add_word(CMD_READ, 0, 0, 0, 0);
        add_word(CMD_READ, SCR_COLS - 1, SCR_ROWS - 1, 0, 0);
        add_word(CMD_READ, 255, 255, 255, 255);
        add_word(CMD_READ, SCR_COLS, 5, 0, 0);
        add_word(CMD_OUTLINE, 10, 10, 0, 0);
        add_word(CMD_READ, 10, 10, 0, 0);
        add_word(CMD_OUTLINE, SCR_COLS - 8, SCR_ROWS - 6, 20, 20);
        add_word(CMD_READ, SCR_COLS - 8, SCR_ROWS - 2, 0, 0);
        add_word(CMD_OUTLINE, 255, 255, 255, 255);
        add_word(CMD_FILL, 20, 2, 0, 5);
        add_word(CMD_READ, 20, 2, 0, 0);
        add_word(CMD_FILL, 30, 3, 4, 2);
        add_word(CMD_READ, 33, 4, 0, 0);
        add_word(CMD_READ, 34, 4, 0, 0);
        add_word(CMD_OUTLINE, 0, 0, SCR_COLS - 1, SCR_ROWS - 1);
        add_word(CMD_UNUSED_LO, 3, 3, 1, 1);
        add_word(CMD_FILL, 0, 0, 255, 255);
        add_word(CMD_UNUSED_HI, 200, 40, 255, 0);
        wait_drained();

        repeat (RANDOM_WORDS / 2)
            add_random_word();
        wait_drained();
        repeat (RANDOM_WORDS - RANDOM_WORDS / 2)
            add_random_word();
        wait_drained();
        repeat (20) @(posedge clk);

        $display("ran %0d commands: %0d clear, %0d plot, %0d outline, %0d fill,",
                 cmd_taken, cmd_kind_count[CMD_CLEAR], cmd_kind_count[CMD_PLOT],
                 cmd_kind_count[CMD_OUTLINE], cmd_kind_count[CMD_FILL]);
        $display("  %0d read, %0d other; checked %0d responses, %0d hit a lit cell, %0d mismatches",
                 cmd_kind_count[CMD_READ],
                 cmd_kind_count[CMD_UNUSED_LO] + cmd_kind_count[CMD_UNUSED_LO + 1]
                 + cmd_kind_count[CMD_UNUSED_HI],
                 rsp_checked, lit_reads, fail_count);
        if (fail_count == 0 && rsp_expect_q.size() == 0)
            $display("rect_draw_framebuffer_top_test: PASS");
        else
            $display("rect_draw_framebuffer_top_test: FAIL");
        $finish;
    end

endmodule
